/* rtl/radio_link_failure_detector_defines.svh */
// Assertion macros shared by the RTL; empty when SYNTHESIS is set.
`ifndef RADIO_LINK_FAILURE_DETECTOR_DEFINES_SVH
`define RADIO_LINK_FAILURE_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define RLFD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlfd: same-cycle check failed");
`define RLFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlfd: next-cycle check failed");
`else
`define RLFD_ASSERT_SAME(lbl, ante, cons)
`define RLFD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/rlfd_pkg.sv */
package rlfd_pkg;

  localparam int unsigned OOS_W      = 5;
  localparam int unsigned IS_W       = 4;
  localparam int unsigned DUR_W      = 13;
  localparam int unsigned STEP_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [1:0] {
    FUNC_TICK        = 2'd0,
    FUNC_IN_SYNC     = 2'd1,
    FUNC_OUT_OF_SYNC = 2'd2,
    FUNC_RESET       = 2'd3
  } func_t;

  localparam logic [CFG_IDX_W-1:0] REG_OOS_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IS_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE = 3'd4;

  localparam logic [OOS_W-1:0]  RST_OOS_LIMIT = 5'd1;
  localparam logic [IS_W-1:0]   RST_IS_LIMIT  = 4'd1;
  localparam logic [DUR_W-1:0]  RST_DURATION  = 13'd1000;
  localparam logic [STEP_W-1:0] RST_TICK_STEP = 10'd10;

  typedef struct packed {
    logic [OOS_W-1:0]  out_of_sync_limit;
    logic [IS_W-1:0]   in_sync_limit;
    logic [DUR_W-1:0]  failure_duration_ms;
    logic [STEP_W-1:0] tick_step_ms;
    logic              test_mode;
  } cfg_t;

  typedef struct packed {
    logic             timer_running;
    logic             link_failed;
    logic             timer_started;
    logic             timer_stopped;
    logic [OOS_W-1:0] bad_count;
    logic [IS_W-1:0]  good_count;
  } result_t;

endpackage

/* rtl/rlfd_in_if.sv */
interface rlfd_in_if;
  logic                  valid;
  logic                  ready;
  rlfd_pkg::func_t       func;
  logic                  other_timer_busy;

  modport source (output valid, output func, output other_timer_busy, input ready);
  modport sink   (input valid, input func, input other_timer_busy, output ready);
endinterface

/* rtl/rlfd_out_if.sv */
interface rlfd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         timer_running;
  logic                         link_failed;
  logic                         timer_started;
  logic                         timer_stopped;
  logic [rlfd_pkg::OOS_W-1:0]   bad_count;
  logic [rlfd_pkg::IS_W-1:0]    good_count;

  modport source (output valid, output timer_running, output link_failed,
                  output timer_started, output timer_stopped, output bad_count,
                  output good_count, input ready);
  modport sink   (input valid, input timer_running, input link_failed,
                  input timer_started, input timer_stopped, input bad_count,
                  input good_count, output ready);
endinterface

/* rtl/rlfd_cfg_if.sv */
interface rlfd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rlfd_pkg::CFG_IDX_W-1:0]    index;
  logic [rlfd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/rlfd_core.sv */
`include "radio_link_failure_detector_defines.svh"

module rlfd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  rlfd_pkg::func_t   func,
  input  logic              other_timer_busy,
  input  rlfd_pkg::cfg_t    cfg,
  output rlfd_pkg::result_t result
);
  import rlfd_pkg::*;

  logic [OOS_W-1:0] bad_counter, bad_counter_next;
  logic [IS_W-1:0]  good_counter, good_counter_next;
  logic             timer_active, timer_active_next;
  logic [DUR_W-1:0] elapsed_ms, elapsed_ms_next;

  logic [DUR_W:0]   sum;
  logic [OOS_W-1:0] bad_inc;
  logic [IS_W-1:0]  good_inc;
  logic             failed, started, stopped;

  assign sum      = {1'b0, elapsed_ms} + {{(DUR_W + 1 - STEP_W){1'b0}}, cfg.tick_step_ms};
  assign bad_inc  = bad_counter + 1'b1;
  assign good_inc = good_counter + 1'b1;

  always_comb begin
    bad_counter_next  = bad_counter;
    good_counter_next = good_counter;
    timer_active_next = timer_active;
    elapsed_ms_next   = elapsed_ms;
    failed            = 1'b0;
    started           = 1'b0;
    stopped           = 1'b0;
    unique case (func)
      FUNC_TICK: begin
        if (timer_active) begin
          if (sum >= {1'b0, cfg.failure_duration_ms}) begin
            failed            = 1'b1;
            timer_active_next = 1'b0;
            elapsed_ms_next   = '0;
          end else begin
            elapsed_ms_next = sum[DUR_W-1:0];
          end
        end
      end
      FUNC_IN_SYNC: begin
        bad_counter_next = '0;
        if (timer_active) begin
          if (good_inc >= cfg.in_sync_limit) begin
            timer_active_next = 1'b0;
            elapsed_ms_next   = '0;
            good_counter_next = '0;
            stopped           = 1'b1;
          end else begin
            good_counter_next = good_inc;
          end
        end
      end
      FUNC_OUT_OF_SYNC: begin
        good_counter_next = '0;
        if (!(cfg.test_mode || other_timer_busy || timer_active)) begin
          if (bad_inc >= cfg.out_of_sync_limit) begin
            timer_active_next = 1'b1;
            elapsed_ms_next   = '0;
            bad_counter_next  = '0;
            started           = 1'b1;
          end else begin
            bad_counter_next = bad_inc;
          end
        end
      end
      FUNC_RESET: begin
        stopped           = timer_active;
        timer_active_next = 1'b0;
        elapsed_ms_next   = '0;
        bad_counter_next  = '0;
        good_counter_next = '0;
      end
      default: begin
        bad_counter_next = bad_counter;
      end
    endcase
  end

  assign result.timer_running = timer_active_next;
  assign result.link_failed   = failed;
  assign result.timer_started = started;
  assign result.timer_stopped = stopped;
  assign result.bad_count     = bad_counter_next;
  assign result.good_count    = good_counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      bad_counter  <= '0;
      good_counter <= '0;
      timer_active <= 1'b0;
      elapsed_ms   <= '0;
    end else if (fire) begin
      bad_counter  <= bad_counter_next;
      good_counter <= good_counter_next;
      timer_active <= timer_active_next;
      elapsed_ms   <= elapsed_ms_next;
    end
  end

  `RLFD_ASSERT_SAME(a_idle_elapsed_zero, !timer_active, elapsed_ms == '0)
  `RLFD_ASSERT_SAME(a_running_bad_zero, timer_active, bad_counter == '0)
  `RLFD_ASSERT_SAME(a_start_only_idle, fire && started, !timer_active)
  `RLFD_ASSERT_NEXT(a_fail_stops, fire && failed, !timer_active && elapsed_ms == '0)

endmodule

/* rtl/radio_link_failure_detector.sv */
// Radio link failure detector (N310/N311/T310). Accepts one tick, in-sync,
// out-of-sync or reset word per clock cycle while the result side takes them
// and returns one result word per input word, valid after the input register
// and then the result register; the counter and timer update is a single pass
// of logic between them, so back-to-back words run at full rate. Registers are
// written through cfg (ready is always high); the user must write them only
// while no word is in flight, as the block itself does not enforce it.
module radio_link_failure_detector (
  input  logic  clk,
  input  logic  rst,
  rlfd_in_if.sink    item,
  rlfd_out_if.source result,
  rlfd_cfg_if.sink   cfg
);
  import rlfd_pkg::*;

  cfg_t    regs;
  logic    stage_valid;
  func_t   stage_func;
  logic    stage_busy;
  logic    advance;
  result_t core_result;
  result_t res;
  logic    res_valid;

  assign cfg.ready  = 1'b1;
  assign advance    = stage_valid && (!res_valid || result.ready);
  assign item.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.out_of_sync_limit   <= RST_OOS_LIMIT;
      regs.in_sync_limit       <= RST_IS_LIMIT;
      regs.failure_duration_ms <= RST_DURATION;
      regs.tick_step_ms        <= RST_TICK_STEP;
      regs.test_mode           <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_OOS_LIMIT: regs.out_of_sync_limit   <= cfg.data[OOS_W-1:0];
        REG_IS_LIMIT:  regs.in_sync_limit       <= cfg.data[IS_W-1:0];
        REG_DURATION:  regs.failure_duration_ms <= cfg.data[DUR_W-1:0];
        REG_TICK_STEP: regs.tick_step_ms        <= cfg.data[STEP_W-1:0];
        REG_TEST_MODE: regs.test_mode           <= cfg.data[0];
        default: begin
          regs <= regs;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage_func <= item.func;
      stage_busy <= item.other_timer_busy;
    end
  end

  rlfd_core u_core (
    .clk              (clk),
    .rst              (rst),
    .fire             (advance),
    .func             (stage_func),
    .other_timer_busy (stage_busy),
    .cfg              (regs),
    .result           (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || result.ready) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= core_result;
    end
  end

  assign result.valid         = res_valid;
  assign result.timer_running = res.timer_running;
  assign result.link_failed   = res.link_failed;
  assign result.timer_started = res.timer_started;
  assign result.timer_stopped = res.timer_stopped;
  assign result.bad_count     = res.bad_count;
  assign result.good_count    = res.good_count;

endmodule

/* tb/radio_link_failure_detector_tb.sv */
`timescale 1ns / 1ps

module radio_link_failure_detector_tb;
  import rlfd_pkg::*;

  typedef struct {
    func_t func;
    logic  busy;
  } stim_word_t;

  logic clk;
  logic rst;

  rlfd_in_if  item_if ();
  rlfd_out_if result_if ();
  rlfd_cfg_if cfg_if ();

  radio_link_failure_detector u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  stim_word_t  pending_words[$];
  stim_word_t  next_word;
  result_t     expected_results[$];
  int unsigned src_hold;
  int unsigned sink_hold;
  bit          no_idle;
  int          fail_count;

  // Link state as the block should hold it
  logic [OOS_W-1:0]  bad_cnt;
  logic [IS_W-1:0]   good_cnt;
  logic              t310_on;
  logic [DUR_W-1:0]  t310_elapsed;

  // Register values as last written
  logic [OOS_W-1:0]  lim_oos;
  logic [IS_W-1:0]   lim_is;
  logic [DUR_W-1:0]  dur_ms;
  logic [STEP_W-1:0] step_ms;
  logic              test_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic rlf_predict(input func_t f, input logic busy);
    result_t     r;
    logic [13:0] sum;
    r = '0;
    case (f)
      FUNC_TICK: begin
        if (t310_on) begin
          sum = {1'b0, t310_elapsed} + step_ms;
          if (sum >= {1'b0, dur_ms}) begin
            r.link_failed = 1'b1;
            t310_on = 1'b0;
            t310_elapsed = '0;
          end else begin
            t310_elapsed = sum[DUR_W-1:0];
          end
        end
      end
      FUNC_IN_SYNC: begin
        bad_cnt = '0;
        if (t310_on) begin
          good_cnt = good_cnt + 1'b1;
          if (good_cnt >= lim_is) begin
            t310_on = 1'b0;
            t310_elapsed = '0;
            good_cnt = '0;
            r.timer_stopped = 1'b1;
          end
        end
      end
      FUNC_OUT_OF_SYNC: begin
        good_cnt = '0;
        if (!(test_on || busy || t310_on)) begin
          bad_cnt = bad_cnt + 1'b1;
          if (bad_cnt >= lim_oos) begin
            t310_on = 1'b1;
            t310_elapsed = '0;
            bad_cnt = '0;
            r.timer_started = 1'b1;
          end
        end
      end
      default: begin
        r.timer_stopped = t310_on;
        t310_on = 1'b0;
        t310_elapsed = '0;
        bad_cnt = '0;
        good_cnt = '0;
      end
    endcase
    r.timer_running = t310_on;
    r.bad_count = bad_cnt;
    r.good_count = good_cnt;
    expected_results.push_back(r);
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result word with nothing expected");
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      if (result_if.timer_running !== want.timer_running) begin
        $error("timer_running: expected %0d, actual %0d", want.timer_running,
               result_if.timer_running);
        fail_count++;
      end
      if (result_if.link_failed !== want.link_failed) begin
        $error("link_failed: expected %0d, actual %0d", want.link_failed,
               result_if.link_failed);
        fail_count++;
      end
      if (result_if.timer_started !== want.timer_started) begin
        $error("timer_started: expected %0d, actual %0d", want.timer_started,
               result_if.timer_started);
        fail_count++;
      end
      if (result_if.timer_stopped !== want.timer_stopped) begin
        $error("timer_stopped: expected %0d, actual %0d", want.timer_stopped,
               result_if.timer_stopped);
        fail_count++;
      end
      if (result_if.bad_count !== want.bad_count) begin
        $error("bad_count: expected %0d, actual %0d", want.bad_count,
               result_if.bad_count);
        fail_count++;
      end
      if (result_if.good_count !== want.good_count) begin
        $error("good_count: expected %0d, actual %0d", want.good_count,
               result_if.good_count);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
      src_hold <= 0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        rlf_predict(item_if.func, item_if.other_timer_busy);
      end
      if (!item_if.valid || item_if.ready) begin
        if (src_hold != 0) begin
          item_if.valid <= 1'b0;
          src_hold <= src_hold - 1;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          item_if.valid <= 1'b1;
          item_if.func <= next_word.func;
          item_if.other_timer_busy <= next_word.busy;
          if (!no_idle && $urandom_range(0, 99) < 30) begin
            src_hold <= pick_gap();
          end
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      sink_hold <= 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        check_result();
      end
      if (sink_hold != 0) begin
        result_if.ready <= 1'b0;
        sink_hold <= sink_hold - 1;
      end else begin
        result_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 25) begin
          sink_hold <= pick_gap();
        end
      end
    end
  end

  task automatic push_word(input func_t f, input logic busy);
    stim_word_t w;
    w.func = f;
    w.busy = busy;
    pending_words.push_back(w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_OOS_LIMIT: lim_oos = value[OOS_W-1:0];
      REG_IS_LIMIT:  lim_is = value[IS_W-1:0];
      REG_DURATION:  dur_ms = value[DUR_W-1:0];
      REG_TICK_STEP: step_ms = value[STEP_W-1:0];
      REG_TEST_MODE: test_on = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [OOS_W-1:0] oos_v, input logic [IS_W-1:0] is_v,
                            input logic [DUR_W-1:0] dur_v, input logic [STEP_W-1:0] step_v,
                            input logic tm_v, input bit junk);
    write_reg(REG_OOS_LIMIT, junk ? {8'($urandom), oos_v} : 13'(oos_v));
    write_reg(REG_IS_LIMIT, junk ? {9'($urandom), is_v} : 13'(is_v));
    write_reg(REG_DURATION, dur_v);
    write_reg(REG_TICK_STEP, junk ? {3'($urandom), step_v} : 13'(step_v));
    write_reg(REG_TEST_MODE, junk ? {12'($urandom), tm_v} : 13'(tm_v));
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || item_if.valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic queue_phase(input int unsigned n_words);
    int unsigned made;
    int unsigned len;
    int unsigned kind;
    made = 0;
    while (made < n_words) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        len = lim_oos + $urandom_range(0, 3);
        if ($urandom_range(0, 5) == 0) begin
          len = $urandom_range(1, lim_oos + 1);
        end
        if (len == 0) begin
          len = 1;
        end
        repeat (len) push_word(FUNC_OUT_OF_SYNC, $urandom_range(0, 19) == 0);
      end else if (kind < 55) begin
        len = $urandom_range(1, 12);
        repeat (len) push_word(FUNC_TICK, 1'($urandom));
      end else if (kind < 80) begin
        len = lim_is + $urandom_range(0, 2);
        if ($urandom_range(0, 5) == 0) begin
          len = $urandom_range(1, lim_is + 1);
        end
        if (len == 0) begin
          len = 1;
        end
        repeat (len) push_word(FUNC_IN_SYNC, 1'($urandom));
      end else if (kind < 88) begin
        len = 1;
        push_word(FUNC_RESET, 1'($urandom));
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) push_word(func_t'($urandom_range(0, 3)), 1'($urandom));
      end
      made += len;
    end
  endtask

  initial begin : main
    int unsigned p;
    int unsigned r;
    int unsigned dur_i;
    logic [OOS_W-1:0]  oos_v;
    logic [IS_W-1:0]   is_v;
    logic [STEP_W-1:0] step_v;
    logic [DUR_W-1:0]  dur_v;

    rst = 1'b1;
    item_if.valid = 1'b0;
    item_if.func = FUNC_TICK;
    item_if.other_timer_busy = 1'b0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_OOS_LIMIT;
    cfg_if.data = '0;
    no_idle = 1'b0;
    fail_count = 0;
    bad_cnt = '0;
    good_cnt = '0;
    t310_on = 1'b0;
    t310_elapsed = '0;
    lim_oos = RST_OOS_LIMIT;
    lim_is = RST_IS_LIMIT;
    dur_ms = RST_DURATION;
    step_ms = RST_TICK_STEP;
    test_on = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: idle cases, blocked out-of-sync, start, stop, reset while running
    push_word(FUNC_TICK, 1'b0);
    push_word(FUNC_IN_SYNC, 1'b0);
    push_word(FUNC_RESET, 1'b0);
    push_word(FUNC_OUT_OF_SYNC, 1'b1);
    push_word(FUNC_OUT_OF_SYNC, 1'b0);
    push_word(FUNC_OUT_OF_SYNC, 1'b0);
    push_word(FUNC_IN_SYNC, 1'b1);
    push_word(FUNC_OUT_OF_SYNC, 1'b0);
    push_word(FUNC_RESET, 1'b1);
    wait_idle();

    // zero limits and zero duration
    set_config('0, '0, '0, '1, 1'b0, 1'b0);
    push_word(FUNC_OUT_OF_SYNC, 1'b0);
    push_word(FUNC_TICK, 1'b0);
    push_word(FUNC_OUT_OF_SYNC, 1'b0);
    push_word(FUNC_IN_SYNC, 1'b0);
    wait_idle();

    // test mode blocks out-of-sync
    set_config('1, '1, '1, '1, 1'b1, 1'b0);
    push_word(FUNC_OUT_OF_SYNC, 1'b0);
    push_word(FUNC_OUT_OF_SYNC, 1'b0);
    push_word(FUNC_IN_SYNC, 1'b0);
    wait_idle();

    // elapsed sum past 13 bits
    set_config(5'd2, 4'd2, '1, '1, 1'b0, 1'b0);
    push_word(FUNC_OUT_OF_SYNC, 1'b0);
    push_word(FUNC_OUT_OF_SYNC, 1'b0);
    repeat (9) push_word(FUNC_TICK, 1'b0);
    wait_idle();

    for (p = 0; p < 12; p++) begin
      if (p == 0) begin
        set_config('1, '1, '1, '1, 1'b0, 1'b0);
      end else if (p == 1) begin
        set_config('0, '0, '0, '0, 1'b0, 1'b0);
      end else begin
        r = $urandom_range(0, 99);
        oos_v = (r < 60) ? 5'($urandom_range(1, 4)) :
                (r < 90) ? 5'($urandom_range(0, 31)) : 5'd0;
        r = $urandom_range(0, 99);
        is_v = (r < 60) ? 4'($urandom_range(1, 4)) :
               (r < 90) ? 4'($urandom_range(0, 15)) : 4'd0;
        r = $urandom_range(0, 99);
        step_v = (r < 50) ? 10'($urandom_range(1, 100)) :
                 (r < 90) ? 10'($urandom_range(1, 1000)) : 10'($urandom_range(0, 1023));
        r = $urandom_range(0, 99);
        if (r < 60) begin
          dur_i = step_v * $urandom_range(0, 8);
        end else if (r < 85) begin
          dur_i = $urandom_range(0, 6000);
        end else begin
          dur_i = $urandom_range(6000, 8191);
        end
        dur_v = (dur_i > 8191) ? 13'd8191 : 13'(dur_i);
        set_config(oos_v, is_v, dur_v, step_v, (p % 5) == 3, (p % 4) == 2);
      end
      if (p == 2) begin
        for (r = REG_TEST_MODE + 1; r < (1 << CFG_IDX_W); r++) begin
          write_reg(CFG_IDX_W'(r), CFG_DATA_W'($urandom));
        end
      end
      no_idle = (p % 4) == 1;
      queue_phase(75);
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
